>>> hdl/irpfd_pkg.sv
// Shared types, constants and window tables for the IR remote pulse frame decoder.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package irpfd_pkg;

    // Default capacity of the frame store, in bytes.
    localparam int BUFFER_BYTES_DEF = 32;

    // Reset values of the two configuration registers.
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] TRAILER_RESET = 8'd1;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_TRAILER_TICKS = 1'b1;

    // Request type codes.
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Frame format codes.
    localparam logic FMT_NEC  = 1'b0;
    localparam logic FMT_AEHA = 1'b1;

    // Byte counts that steer frame completion and timer arming.
    localparam int NEC_FRAME_BYTES   = 4;
    localparam int TRAILER_ARM_BYTES = 3;
    localparam int TIMEOUT_KEEP_IDX  = 3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] pulse_width;
        logic        width_overflow;
    } t_in_req;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [4:0] byte_index;
        logic       frame_format;
        logic       last_byte;
    } t_out_res;

    // Pulse windows, in the order they are tried; the two repeat windows are never tried.
    typedef enum logic [2:0] {
        WIN_NEC_LEAD  = 3'd0,
        WIN_AEHA_LEAD = 3'd1,
        WIN_NEC_ZERO  = 3'd2,
        WIN_NEC_ONE   = 3'd3,
        WIN_AEHA_ZERO = 3'd4,
        WIN_AEHA_ONE  = 3'd5,
        WIN_NEC_REP   = 3'd6,
        WIN_AEHA_REP  = 3'd7
    } t_win;

    // Sequencer states.
    typedef enum logic [1:0] {
        SQ_READY   = 2'd0,
        SQ_CLASS   = 2'd1,
        SQ_EMIT_RD = 2'd2,
        SQ_EMIT_WR = 2'd3
    } t_seq;

    // Frame reception state.
    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_NEC  = 2'd1,
        FS_AEHA = 2'd2
    } t_frame;

    // Window centers and tolerances in 2 us units.
    localparam logic [15:0] WIN_CENTER [8] = '{
        16'd6744, 16'd2550, 16'd562, 16'd1124, 16'd425, 16'd850, 16'd5620, 16'd3400
    };
    localparam logic [15:0] WIN_TOL [8] = '{
        16'd674, 16'd255, 16'd56, 16'd112, 16'd42, 16'd85, 16'd562, 16'd340
    };

    // Exclusive lower bound of a window.
    function automatic logic [15:0] win_lo(input t_win k);
        return WIN_CENTER[k] - WIN_TOL[k];
    endfunction

    // Exclusive upper bound of a window.
    function automatic logic [15:0] win_hi(input t_win k);
        return WIN_CENTER[k] + WIN_TOL[k];
    endfunction

endpackage

>>> hdl/ir_remote_pulse_frame_decoder.sv
// Top level of the IR remote pulse frame decoder (NEC and AEHA formats).
// Depends on irpfd_pkg for payload structs, state enums, window tables and constants.
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ---------------------------------
//  in        to block   i_in_valid / o_in_stall    irpfd_pkg::t_in_req (width or tick)
//  out       from block o_out_valid / i_out_stall  irpfd_pkg::t_out_res (one byte)
//  cfg       to block   i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// A tick request is handled as it is accepted. A pulse request is accepted and then the
// windows are tried one at a time by the single shared window comparator, up to six windows.
// Emitting a frame passes through a read state and a write state for each stored byte, due
// to the registered read port of the frame store, and waits while the output is stalled.
// Reset is synchronous and active low; it needs no clearing pass since the frame store is
// only read at entries written in the current frame.
// The output register lets a finished byte wait while the sequencer goes on.
module ir_remote_pulse_frame_decoder #(
    parameter int BUFFER_BYTES = irpfd_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  irpfd_pkg::t_in_req   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output irpfd_pkg::t_out_res  o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [7:0]           i_cfg_wdata
);

    // AW indexes the frame store; CW holds a byte count up to BUFFER_BYTES.
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    localparam logic [CW-1:0] FULL_CNT   = CW'(BUFFER_BYTES);
    localparam logic [CW-1:0] NEC_CNT    = CW'(irpfd_pkg::NEC_FRAME_BYTES);
    localparam logic [CW-1:0] TRL_CNT    = CW'(irpfd_pkg::TRAILER_ARM_BYTES);
    localparam logic [CW-1:0] TO_KEEP    = CW'(irpfd_pkg::TIMEOUT_KEEP_IDX);

    // Sequencer and frame state.
    irpfd_pkg::t_seq   r_seq, n_seq;
    irpfd_pkg::t_frame r_frame, n_frame;
    irpfd_pkg::t_win   r_win, n_win;

    // Configuration registers.
    logic [7:0] r_timeout_ticks;
    logic [7:0] r_trailer_ticks;

    // Frame assembly state.
    logic [7:0]    r_shift, n_shift;
    logic [2:0]    r_bit_cnt, n_bit_cnt;
    logic [CW-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]    r_to_left, n_to_left;
    logic [7:0]    r_trl_left, n_trl_left;
    logic          r_to_armed, n_to_armed;
    logic          r_trl_armed, n_trl_armed;

    // Pulse width held while the windows are tried.
    logic [15:0] r_width, n_width;

    // Frame store and its registered read port.
    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          mem_we;

    // Output register.
    logic                r_out_valid, n_out_valid;
    irpfd_pkg::t_out_res r_out, n_out;

    // Internal control flags of the combinational block.
    logic do_idle;
    logic do_start;
    logic start_aeha;
    logic win_hit;
    logic bit_one;
    logic in_take;
    logic to_exp;
    logic trl_exp;

    assign o_in_stall  = (r_seq != irpfd_pkg::SQ_READY);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_take     = i_in_valid && (r_seq == irpfd_pkg::SQ_READY);

    // The shared window comparator: both bounds are exclusive.
    assign win_hit = (irpfd_pkg::win_lo(r_win) < r_width) &&
                     (r_width < irpfd_pkg::win_hi(r_win));
    assign bit_one = (r_win == irpfd_pkg::WIN_NEC_ONE) || (r_win == irpfd_pkg::WIN_AEHA_ONE);

    // Each armed timer expires on a tick that finds it already at zero.
    assign to_exp  = r_to_armed && (r_to_left == 8'd0);
    assign trl_exp = r_trl_armed && (r_trl_left == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq           <= irpfd_pkg::SQ_READY;
            r_frame         <= irpfd_pkg::FS_IDLE;
            r_win           <= irpfd_pkg::WIN_NEC_LEAD;
            r_timeout_ticks <= irpfd_pkg::TIMEOUT_RESET;
            r_trailer_ticks <= irpfd_pkg::TRAILER_RESET;
            r_shift         <= 8'd0;
            r_bit_cnt       <= 3'd0;
            r_byte_cnt      <= '0;
            r_to_left       <= irpfd_pkg::TIMEOUT_RESET;
            r_trl_left      <= irpfd_pkg::TRAILER_RESET;
            r_to_armed      <= 1'b0;
            r_trl_armed     <= 1'b0;
            r_rd_idx        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_frame     <= n_frame;
            r_win       <= n_win;
            r_shift     <= n_shift;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_to_left   <= n_to_left;
            r_trl_left  <= n_trl_left;
            r_to_armed  <= n_to_armed;
            r_trl_armed <= n_trl_armed;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            // Register writes only land in the reload values.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    irpfd_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata;
                    irpfd_pkg::CFG_TRAILER_TICKS: r_trailer_ticks <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_out   <= n_out;
    end

    // Frame store: one write port at the running byte count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_byte_cnt[AW-1:0]] <= n_shift;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_comb begin
        n_seq       = r_seq;
        n_frame     = r_frame;
        n_win       = r_win;
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_to_left   = r_to_left;
        n_trl_left  = r_trl_left;
        n_to_armed  = r_to_armed;
        n_trl_armed = r_trl_armed;
        n_width     = r_width;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        do_idle     = 1'b0;
        do_start    = 1'b0;
        start_aeha  = 1'b0;

        case (r_seq)
            irpfd_pkg::SQ_READY: begin
                if (in_take) begin
                    if (i_in.req_type == irpfd_pkg::REQ_TICK) begin
                        // Trailer expiry wins over a receive timeout on the same tick.
                        if (trl_exp) begin
                            n_rd_idx = '0;
                            n_seq    = irpfd_pkg::SQ_EMIT_RD;
                        end else if (to_exp) begin
                            do_idle = 1'b1;
                        end else begin
                            if (r_to_armed) begin
                                n_to_left = r_to_left - 8'd1;
                            end
                            if (r_trl_armed) begin
                                n_trl_left = r_trl_left - 8'd1;
                            end
                        end
                    end else if (i_in.width_overflow) begin
                        do_idle = 1'b1;
                    end else begin
                        n_width = i_in.pulse_width;
                        n_win   = irpfd_pkg::WIN_NEC_LEAD;
                        n_seq   = irpfd_pkg::SQ_CLASS;
                    end
                end
            end

            irpfd_pkg::SQ_CLASS: begin
                if (win_hit) begin
                    n_seq = irpfd_pkg::SQ_READY;
                    case (r_win)
                        irpfd_pkg::WIN_NEC_LEAD: begin
                            do_start = 1'b1;
                        end
                        irpfd_pkg::WIN_AEHA_LEAD: begin
                            do_start   = 1'b1;
                            start_aeha = 1'b1;
                        end
                        default: begin
                            // A data bit; ignored while no frame is open.
                            if (r_frame != irpfd_pkg::FS_IDLE) begin
                                n_shift   = {bit_one, r_shift[7:1]};
                                n_bit_cnt = r_bit_cnt + 3'd1;
                                if (n_bit_cnt == 3'd0) begin
                                    if (r_byte_cnt >= FULL_CNT) begin
                                        do_idle = 1'b1;
                                    end else begin
                                        if (r_frame == irpfd_pkg::FS_AEHA &&
                                            r_byte_cnt > TO_KEEP) begin
                                            n_to_armed = 1'b0;
                                        end
                                        mem_we     = 1'b1;
                                        n_byte_cnt = r_byte_cnt + CW'(1);
                                        if (r_frame == irpfd_pkg::FS_NEC) begin
                                            if (n_byte_cnt >= NEC_CNT ||
                                                n_byte_cnt >= FULL_CNT) begin
                                                n_rd_idx = '0;
                                                n_seq    = irpfd_pkg::SQ_EMIT_RD;
                                            end
                                        end else if (n_byte_cnt >= FULL_CNT) begin
                                            n_rd_idx = '0;
                                            n_seq    = irpfd_pkg::SQ_EMIT_RD;
                                        end else if (n_byte_cnt >= TRL_CNT) begin
                                            n_trl_left  = r_trailer_ticks;
                                            n_trl_armed = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end else if (r_win == irpfd_pkg::WIN_AEHA_ONE) begin
                    // Repeat codes and unmatched widths leave everything as it is.
                    n_seq = irpfd_pkg::SQ_READY;
                end else begin
                    n_win = irpfd_pkg::t_win'(r_win + 3'd1);
                end
            end

            irpfd_pkg::SQ_EMIT_RD: begin
                // The store read address is r_rd_idx; data is ready next cycle.
                n_seq = irpfd_pkg::SQ_EMIT_WR;
            end

            irpfd_pkg::SQ_EMIT_WR: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out.byte_value       = r_rd_data;
                    n_out.byte_index       = 5'(r_rd_idx);
                    n_out.frame_format     = (r_frame == irpfd_pkg::FS_AEHA) ?
                                             irpfd_pkg::FMT_AEHA : irpfd_pkg::FMT_NEC;
                    n_out.last_byte        = ((CW'(r_rd_idx) + CW'(1)) == r_byte_cnt);
                    if (n_out.last_byte) begin
                        do_idle = 1'b1;
                        n_seq   = irpfd_pkg::SQ_READY;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                        n_seq    = irpfd_pkg::SQ_EMIT_RD;
                    end
                end
            end

            default: begin
                n_seq = irpfd_pkg::SQ_READY;
            end
        endcase

        // Going idle, also the first half of starting a new frame.
        if (do_idle || do_start) begin
            n_frame     = irpfd_pkg::FS_IDLE;
            n_shift     = 8'd0;
            n_bit_cnt   = 3'd0;
            n_byte_cnt  = '0;
            n_to_armed  = 1'b0;
            n_trl_armed = 1'b0;
            n_to_left   = r_timeout_ticks;
            n_trl_left  = r_trailer_ticks;
        end
        if (do_start) begin
            n_frame    = start_aeha ? irpfd_pkg::FS_AEHA : irpfd_pkg::FS_NEC;
            n_to_armed = 1'b1;
        end
    end

endmodule
